>>> sv/bgti_pkg.sv
// Shared types and constants of the bilinear grid table interpolator.
package bgti_pkg;

  // Default table bounds handed to the top level.
  localparam int MAX_SPEED_BINS_DEF     = 16;
  localparam int MAX_DIRECTION_BINS_DEF = 64;
  localparam int MAX_UNITS_DEF          = 8;

  // Configuration port geometry and register reset values.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam int SPEED_BINS_RST     = 2;
  localparam int DIRECTION_BINS_RST = 2;
  localparam int UNITS_RST          = 1;
  localparam int MIN_BINS           = 2;
  localparam int MIN_UNITS          = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_BINS     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_BINS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNITS          = 2'd2;

  // Fixed-point widths.
  localparam int VAL_W  = 16;
  localparam int WGT_W  = 16;
  localparam int FACT_W = 33;
  localparam int ACC_W  = 50;

  typedef enum logic [1:0] {
    OP_WR_SPEED = 2'd0,
    OP_WR_DIR   = 2'd1,
    OP_WR_GRID  = 2'd2,
    OP_LOOKUP   = 2'd3
  } opcode_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic [3:0]               speed_index;
    logic [5:0]               direction_index;
    logic [2:0]               unit_index;
    logic signed [VAL_W-1:0]  write_value;
    logic signed [VAL_W-1:0]  query_speed;
    logic signed [VAL_W-1:0]  query_direction;
  } in_word_t;

  typedef struct packed {
    logic [2:0]               unit_number;
    logic signed [VAL_W-1:0]  setpoint;
    logic                     last;
  } out_word_t;

endpackage

>>> sv/bgti_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bgti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/bilinear_grid_table_interpolator_core.sv
// A write word is accepted in idle. A lookup searches each axis in turn: a point at or below the
// first breakpoint or at or above the last is clamped, else breakpoints are scanned one by one,
// and a restoring divider forms the weight when the point falls between breakpoints.
// Then the four corner factors are formed, and each unit needs 4 grid reads through
// the single grid RAM read port, multiply, accumulate and round, plus any out_stall wait.
// One word at a time. Reset (sync, rst_n low) clears control and config.
module bilinear_grid_table_interpolator_core
  import bgti_pkg::*;
#(
  parameter int MAX_SPEED_BINS     = MAX_SPEED_BINS_DEF,
  parameter int MAX_DIRECTION_BINS = MAX_DIRECTION_BINS_DEF,
  parameter int MAX_UNITS          = MAX_UNITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SI_W   = $clog2(MAX_SPEED_BINS);
  localparam int DI_W   = $clog2(MAX_DIRECTION_BINS);
  localparam int H_W    = (SI_W > DI_W) ? SI_W : DI_W;
  localparam int N_W    = H_W + 1;
  localparam int UI_W   = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;
  localparam int UN_W   = $clog2(MAX_UNITS + 1);
  localparam int GDEPTH = MAX_SPEED_BINS * MAX_DIRECTION_BINS * MAX_UNITS;
  localparam int GA_W   = $clog2(GDEPTH);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_B0    = 10'b00_0000_0010,
    ST_BL    = 10'b00_0000_0100,
    ST_BC    = 10'b00_0000_1000,
    ST_SCAN  = 10'b00_0001_0000,
    ST_DIV   = 10'b00_0010_0000,
    ST_FACT  = 10'b00_0100_0000,
    ST_ISSUE = 10'b00_1000_0000,
    ST_DRAIN = 10'b01_0000_0000,
    ST_SPARE = 10'b10_0000_0000
  } state_t;

  function automatic logic [GA_W-1:0] gaddr(input logic [H_W-1:0] s,
                                            input logic [H_W-1:0] d,
                                            input logic [UI_W-1:0] u);
    gaddr = GA_W'((32'(s) * 32'(MAX_DIRECTION_BINS) + 32'(d)) * 32'(MAX_UNITS) + 32'(u));
  endfunction

  // Registers.
  state_t                  state_r, state_nxt;
  logic [N_W-1:0]          spd_n_r, spd_n_nxt;
  logic [N_W-1:0]          dir_n_r, dir_n_nxt;
  logic [UN_W-1:0]         units_r, units_nxt;
  logic                    axis_r, axis_nxt;
  logic signed [VAL_W-1:0] qs_r, qs_nxt, qd_r, qd_nxt;
  logic signed [VAL_W-1:0] prev_r, prev_nxt;
  logic [H_W-1:0]          h_r, h_nxt;
  logic [H_W-1:0]          s_lo_r, s_lo_nxt, s_hi_r, s_hi_nxt;
  logic [H_W-1:0]          d_lo_r, d_lo_nxt, d_hi_r, d_hi_nxt;
  logic [H_W-1:0]          blo_r, blo_nxt, bhi_r, bhi_nxt;
  logic [WGT_W-1:0]        ws_r, ws_nxt, wd_r, wd_nxt;
  logic [VAL_W:0]          rem_r, rem_nxt, span_r, span_nxt;
  logic [WGT_W-1:0]        quo_r, quo_nxt;
  logic [3:0]              div_cnt_r, div_cnt_nxt;
  logic [1:0]              k_r, k_nxt;
  logic [FACT_W-1:0]       fact_r [4];
  logic [FACT_W-1:0]       fact_nxt;
  logic                    fact_we;
  logic [UI_W-1:0]         u_r, u_nxt;
  logic                    rd_v_r, rd_v_nxt;
  logic [1:0]              rd_k_r, rd_k_nxt;
  logic                    prod_v_r, prod_v_nxt;
  logic [1:0]              prod_k_r, prod_k_nxt;
  logic signed [ACC_W-1:0] prod_r, prod_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    acc_rdy_r, acc_rdy_nxt;
  logic                    out_valid_r, out_valid_nxt;
  out_word_t               out_data_r, out_data_nxt;

  // Combinational signals.
  logic                    in_acc;
  logic                    out_free;
  logic [H_W-1:0]          last_idx;
  logic [H_W-1:0]          bp_raddr;
  logic [GA_W-1:0]         grid_raddr;
  logic [VAL_W-1:0]        sbp_rdata, dbp_rdata, grid_rdata;
  logic signed [VAL_W-1:0] bp_rd, q;
  logic signed [VAL_W:0]   diff_num, diff_span;
  logic [VAL_W+1:0]        rem2;
  logic [VAL_W:0]          fa, fb;
  logic signed [ACC_W-1:0] rnd;
  logic signed [17:0]      res18;
  logic signed [VAL_W-1:0] res_sat;
  logic                    sbp_we, dbp_we, grid_we;
  logic [GA_W-1:0]         grid_waddr;
  logic                    unit_last;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign last_idx = axis_r ? H_W'(dir_n_r - N_W'(1)) : H_W'(spd_n_r - N_W'(1));
  assign bp_rd    = axis_r ? $signed(dbp_rdata) : $signed(sbp_rdata);
  assign q        = axis_r ? qd_r : qs_r;

  assign diff_num  = $signed({q[VAL_W-1], q}) - $signed({prev_r[VAL_W-1], prev_r});
  assign diff_span = $signed({bp_rd[VAL_W-1], bp_rd}) - $signed({prev_r[VAL_W-1], prev_r});
  assign rem2      = {rem_r, 1'b0};

  assign fa = k_r[1] ? {1'b0, ws_r} : ((VAL_W+1)'(1) << WGT_W) - {1'b0, ws_r};
  assign fb = k_r[0] ? {1'b0, wd_r} : ((VAL_W+1)'(1) << WGT_W) - {1'b0, wd_r};

  assign unit_last = (UN_W'(u_r) + UN_W'(1)) == units_r;

  // Round half up to Q8.8 and saturate.
  always_comb begin
    rnd   = acc_r + (ACC_W'(1) <<< 31);
    res18 = rnd[ACC_W-1:32];
    if (res18 > 18'sd32767) begin
      res_sat = 16'sh7fff;
    end else if (res18 < -18'sd32768) begin
      res_sat = 16'sh8000;
    end else begin
      res_sat = res18[VAL_W-1:0];
    end
  end

  // Table writes from accepted write words, with out-of-range indexes dropped.
  assign sbp_we  = in_acc && (in_data.opcode == OP_WR_SPEED)
                   && (32'(in_data.speed_index) < MAX_SPEED_BINS);
  assign dbp_we  = in_acc && (in_data.opcode == OP_WR_DIR)
                   && (32'(in_data.direction_index) < MAX_DIRECTION_BINS);
  assign grid_we = in_acc && (in_data.opcode == OP_WR_GRID)
                   && (32'(in_data.speed_index) < MAX_SPEED_BINS)
                   && (32'(in_data.direction_index) < MAX_DIRECTION_BINS)
                   && (32'(in_data.unit_index) < MAX_UNITS);
  assign grid_waddr = gaddr(H_W'(in_data.speed_index), H_W'(in_data.direction_index),
                            UI_W'(in_data.unit_index));

  bgti_ram #(.WIDTH(VAL_W), .DEPTH(MAX_SPEED_BINS)) u_speed_bp (
    .clk(clk), .wr_en(sbp_we), .wr_addr(SI_W'(in_data.speed_index)),
    .wr_data(in_data.write_value), .rd_addr(bp_raddr[SI_W-1:0]), .rd_data(sbp_rdata)
  );

  bgti_ram #(.WIDTH(VAL_W), .DEPTH(MAX_DIRECTION_BINS)) u_dir_bp (
    .clk(clk), .wr_en(dbp_we), .wr_addr(DI_W'(in_data.direction_index)),
    .wr_data(in_data.write_value), .rd_addr(bp_raddr[DI_W-1:0]), .rd_data(dbp_rdata)
  );

  bgti_ram #(.WIDTH(VAL_W), .DEPTH(GDEPTH)) u_grid (
    .clk(clk), .wr_en(grid_we), .wr_addr(grid_waddr),
    .wr_data(in_data.write_value), .rd_addr(grid_raddr), .rd_data(grid_rdata)
  );

  // Sequencer: bracket search, divider, factors and per-unit corner reads.
  always_comb begin
    state_nxt    = state_r;
    axis_nxt     = axis_r;
    qs_nxt       = qs_r;
    qd_nxt       = qd_r;
    prev_nxt     = prev_r;
    h_nxt        = h_r;
    s_lo_nxt     = s_lo_r;
    s_hi_nxt     = s_hi_r;
    d_lo_nxt     = d_lo_r;
    d_hi_nxt     = d_hi_r;
    blo_nxt      = blo_r;
    bhi_nxt      = bhi_r;
    ws_nxt       = ws_r;
    wd_nxt       = wd_r;
    rem_nxt      = rem_r;
    span_nxt     = span_r;
    quo_nxt      = quo_r;
    div_cnt_nxt  = div_cnt_r;
    k_nxt        = k_r;
    u_nxt        = u_r;
    fact_we      = 1'b0;
    fact_nxt     = FACT_W'(fa) * FACT_W'(fb);
    bp_raddr     = '0;
    grid_raddr   = gaddr(k_r[1] ? s_hi_r : s_lo_r, k_r[0] ? d_hi_r : d_lo_r, u_r);
    rd_v_nxt     = 1'b0;
    rd_k_nxt     = k_r;
    acc_rdy_nxt  = acc_rdy_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt = out_data_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && (in_data.opcode == OP_LOOKUP)) begin
          qs_nxt    = in_data.query_speed;
          qd_nxt    = in_data.query_direction;
          axis_nxt  = 1'b0;
          state_nxt = ST_B0;
        end
      end
      ST_B0: begin
        bp_raddr  = '0;
        state_nxt = ST_BL;
      end
      ST_BL: begin
        bp_raddr = last_idx;
        if (q <= bp_rd) begin
          blo_nxt   = '0;
          bhi_nxt   = '0;
          quo_nxt   = '0;
          state_nxt = ST_SPARE;
        end else begin
          prev_nxt  = bp_rd;
          state_nxt = ST_BC;
        end
      end
      ST_BC: begin
        bp_raddr = H_W'(1);
        if (q >= bp_rd) begin
          blo_nxt   = last_idx;
          bhi_nxt   = last_idx;
          quo_nxt   = '0;
          state_nxt = ST_SPARE;
        end else begin
          h_nxt     = H_W'(1);
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        bp_raddr = (h_r == last_idx) ? h_r : h_r + H_W'(1);
        if ((bp_rd >= q) || (h_r == last_idx)) begin
          if (bp_rd == q) begin
            blo_nxt   = h_r;
            bhi_nxt   = h_r;
            quo_nxt   = '0;
            state_nxt = ST_SPARE;
          end else begin
            blo_nxt     = h_r - H_W'(1);
            bhi_nxt     = h_r;
            rem_nxt     = diff_num[VAL_W:0];
            span_nxt    = diff_span[VAL_W:0];
            div_cnt_nxt = '0;
            state_nxt   = ST_DIV;
          end
        end else begin
          prev_nxt = bp_rd;
          h_nxt    = h_r + H_W'(1);
        end
      end
      ST_DIV: begin
        // One restoring quotient bit per cycle.
        if (rem2 >= {1'b0, span_r}) begin
          rem_nxt = (VAL_W+1)'(rem2 - {1'b0, span_r});
          quo_nxt = {quo_r[WGT_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem2[VAL_W:0];
          quo_nxt = {quo_r[WGT_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + 4'd1;
        if (div_cnt_r == 4'd15) begin
          state_nxt = ST_SPARE;
        end
      end
      ST_SPARE: begin
        // Axis finished: file its bracket and weight.
        if (!axis_r) begin
          s_lo_nxt  = blo_r;
          s_hi_nxt  = bhi_r;
          ws_nxt    = quo_r;
          axis_nxt  = 1'b1;
          state_nxt = ST_B0;
        end else begin
          d_lo_nxt  = blo_r;
          d_hi_nxt  = bhi_r;
          wd_nxt    = quo_r;
          k_nxt     = 2'd0;
          state_nxt = ST_FACT;
        end
      end
      ST_FACT: begin
        fact_we = 1'b1;
        k_nxt   = k_r + 2'd1;
        if (k_r == 2'd3) begin
          u_nxt     = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        rd_v_nxt = 1'b1;
        k_nxt    = k_r + 2'd1;
        if (k_r == 2'd3) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (acc_rdy_r && out_free) begin
          acc_rdy_nxt              = 1'b0;
          out_valid_nxt            = 1'b1;
          out_data_nxt.unit_number = 3'(u_r);
          out_data_nxt.setpoint    = res_sat;
          out_data_nxt.last        = unit_last;
          k_nxt                    = 2'd0;
          if (unit_last) begin
            state_nxt = ST_IDLE;
          end else begin
            u_nxt     = u_r + UI_W'(1);
            state_nxt = ST_ISSUE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (prod_v_r && (prod_k_r == 2'd3)) begin
      acc_rdy_nxt = 1'b1;
    end
  end

  // Multiply-accumulate pipeline behind the grid read port.
  always_comb begin
    prod_v_nxt = rd_v_r;
    prod_k_nxt = rd_k_r;
    prod_nxt   = $signed(grid_rdata) * $signed({1'b0, fact_r[rd_k_r]});
    acc_nxt    = acc_r;
    if (prod_v_r) begin
      acc_nxt = ((prod_k_r == 2'd0) ? ACC_W'(0) : acc_r) + prod_r;
    end
  end

  // Configuration writes, masked and saturated into range.
  always_comb begin
    spd_n_nxt = spd_n_r;
    dir_n_nxt = dir_n_r;
    units_nxt = units_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SPEED_BINS: begin
          if (32'(cfg_wdata[4:0]) < MIN_BINS) begin
            spd_n_nxt = N_W'(MIN_BINS);
          end else if (32'(cfg_wdata[4:0]) > MAX_SPEED_BINS) begin
            spd_n_nxt = N_W'(MAX_SPEED_BINS);
          end else begin
            spd_n_nxt = N_W'(cfg_wdata[4:0]);
          end
        end
        CFG_DIRECTION_BINS: begin
          if (32'(cfg_wdata[6:0]) < MIN_BINS) begin
            dir_n_nxt = N_W'(MIN_BINS);
          end else if (32'(cfg_wdata[6:0]) > MAX_DIRECTION_BINS) begin
            dir_n_nxt = N_W'(MAX_DIRECTION_BINS);
          end else begin
            dir_n_nxt = N_W'(cfg_wdata[6:0]);
          end
        end
        CFG_UNITS: begin
          if (32'(cfg_wdata[3:0]) < MIN_UNITS) begin
            units_nxt = UN_W'(MIN_UNITS);
          end else if (32'(cfg_wdata[3:0]) > MAX_UNITS) begin
            units_nxt = UN_W'(MAX_UNITS);
          end else begin
            units_nxt = UN_W'(cfg_wdata[3:0]);
          end
        end
        default: begin
          spd_n_nxt = spd_n_r;
        end
      endcase
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      spd_n_r     <= N_W'(SPEED_BINS_RST);
      dir_n_r     <= N_W'(DIRECTION_BINS_RST);
      units_r     <= UN_W'(UNITS_RST);
      rd_v_r      <= 1'b0;
      prod_v_r    <= 1'b0;
      acc_rdy_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      spd_n_r     <= spd_n_nxt;
      dir_n_r     <= dir_n_nxt;
      units_r     <= units_nxt;
      rd_v_r      <= rd_v_nxt;
      prod_v_r    <= prod_v_nxt;
      acc_rdy_r   <= acc_rdy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    axis_r     <= axis_nxt;
    qs_r       <= qs_nxt;
    qd_r       <= qd_nxt;
    prev_r     <= prev_nxt;
    h_r        <= h_nxt;
    s_lo_r     <= s_lo_nxt;
    s_hi_r     <= s_hi_nxt;
    d_lo_r     <= d_lo_nxt;
    d_hi_r     <= d_hi_nxt;
    blo_r      <= blo_nxt;
    bhi_r      <= bhi_nxt;
    ws_r       <= ws_nxt;
    wd_r       <= wd_nxt;
    rem_r      <= rem_nxt;
    span_r     <= span_nxt;
    quo_r      <= quo_nxt;
    div_cnt_r  <= div_cnt_nxt;
    k_r        <= k_nxt;
    u_r        <= u_nxt;
    rd_k_r     <= rd_k_nxt;
    prod_k_r   <= prod_k_nxt;
    prod_r     <= prod_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    if (fact_we) begin
      fact_r[k_r] <= fact_nxt;
    end
  end

`ifndef SYNTH
  // The divider remainder always stays below the bracket span.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < span_r))
    else $error("divider remainder not below span");

  // A finished sum waiting on a busy output is kept.
  a_acc_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_rdy_r && !out_free) |=> acc_rdy_r)
    else $error("finished unit sum dropped");

  // Grid reads come only from the corner issue phase.
  a_rd_src: assert property (@(posedge clk) disable iff (!rst_n)
    rd_v_r |-> $past(state_r == ST_ISSUE))
    else $error("grid read outside issue phase");
`endif

endmodule
